// ----- sv/bitmap_cluster_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Bitmap cluster allocator assertion macros
// Shorthand for the clocked, reset-qualified properties of the checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_CLUSTER_ALLOCATOR_MACROS_SVH
`define BITMAP_CLUSTER_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define BCA_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while reset is released.
`define BCA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bca_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap cluster allocator package
// Shared codes, widths, the result type and the lowest-set-bit search.
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int unsigned MAP_WORDS_DEF = 1024;
  localparam int unsigned WORD_REACH    = 1024;
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned BIT_W         = 6;
  localparam int unsigned CLUSTER_W     = 16;
  localparam int unsigned WIDX_W        = CLUSTER_W - BIT_W;
  localparam int unsigned CFG_W         = 11;
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [CFG_W-1:0] WORDS_RESET = CFG_W'(WORD_REACH);

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MARK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAPRD,
    S_UPD
  } state_e;

  typedef struct packed {
    logic [CLUSTER_W-1:0] granted;
    logic [STATUS_W-1:0]  status;
  } res_t;

  // Index of the lowest set bit, found by six halving steps.
  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] x;
    logic [BIT_W-1:0]     idx;
    x   = v;
    idx = '0;
    for (int s = BIT_W - 1; s >= 0; s--) begin
      if ((x & ((64'd1 << (1 << s)) - 64'd1)) == 64'd0) begin
        idx[s] = 1'b1;
        x      = x >> (1 << s);
      end
    end
    return idx;
  endfunction

endpackage

// ----- sv/bca_ram.sv -----
// ----------------------------------------------------------------------------
// Bitmap cluster allocator RAM
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bca_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bca_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bitmap cluster allocator control
// Clears the maps after reset, then reads, modifies and writes back the
// bitmap and its per-word full summary for each request that updates a cluster.
// ----------------------------------------------------------------------------
module bca_ctrl
  import bca_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned NG    = 16,
  parameter int unsigned GW    = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [CLUSTER_W-1:0] cluster_i,
  input  logic [CFG_W-1:0]     nwords_i,
  input  logic                 out_free_i,
  output logic                 res_valid_o,
  output res_t                 res_o,
  output logic                 map_we_o,
  output logic [AW-1:0]        map_waddr_o,
  output logic [WORD_BITS-1:0] map_wdata_o,
  output logic                 map_re_o,
  output logic [AW-1:0]        map_raddr_o,
  input  logic [WORD_BITS-1:0] map_rdata_i,
  output logic                 sum_we_o,
  output logic [GW-1:0]        sum_waddr_o,
  output logic [WORD_BITS-1:0] sum_wdata_o,
  output logic                 sum_re_o,
  output logic [GW-1:0]        sum_raddr_o,
  input  logic [WORD_BITS-1:0] sum_rdata_i
);

  state_e                state_q, state_d;
  logic [REQ_W-1:0]      op_q, op_d;
  logic [WIDX_W-1:0]     word_q, word_d;
  logic [BIT_W-1:0]      bit_q, bit_d;
  logic                  skip_q, skip_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [NG-1:0]         grp_nf_q, grp_nf_d;

  logic [BIT_W-1:0]      grp_first;
  logic [BIT_W-1:0]      sub_first;
  logic [BIT_W-1:0]      map_first;
  logic [WIDX_W-1:0]     alloc_word;
  logic [GW-1:0]         cur_grp;
  logic [WORD_BITS-1:0]  bit_oh;
  logic [WORD_BITS-1:0]  sub_oh;
  logic [WORD_BITS-1:0]  map_new;
  logic [WORD_BITS-1:0]  sum_new;

  assign grp_first  = lowest_one(WORD_BITS'(grp_nf_q));
  assign sub_first  = lowest_one(~sum_rdata_i);
  assign map_first  = lowest_one(~map_rdata_i);
  assign alloc_word = word_q | WIDX_W'(sub_first);
  assign cur_grp    = word_q[GW+BIT_W-1:BIT_W];
  assign sub_oh     = WORD_BITS'(1) << word_q[BIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      grp_nf_q <= '1;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      grp_nf_q <= grp_nf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    word_q   <= word_d;
    bit_q    <= bit_d;
    skip_q   <= skip_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    word_d      = word_q;
    bit_d       = bit_q;
    skip_d      = skip_q;
    status_d    = status_q;
    clr_d       = clr_q;
    grp_nf_d    = grp_nf_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    res_o       = '{granted: '0, status: status_q};
    map_we_o    = 1'b0;
    map_waddr_o = word_q[AW-1:0];
    map_wdata_o = '0;
    map_re_o    = 1'b0;
    map_raddr_o = word_q[AW-1:0];
    sum_we_o    = 1'b0;
    sum_waddr_o = cur_grp;
    sum_wdata_o = '0;
    sum_re_o    = 1'b0;
    sum_raddr_o = cur_grp;
    bit_oh      = '0;
    map_new     = '0;
    sum_new     = '0;

    case (state_q)
      S_CLEAR: begin
        map_we_o    = 1'b1;
        map_waddr_o = clr_q;
        sum_we_o    = (32'(clr_q) < NG);
        sum_waddr_o = clr_q[GW-1:0];
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_d     = req_type_i;
          word_d   = cluster_i[CLUSTER_W-1:BIT_W];
          bit_d    = cluster_i[BIT_W-1:0];
          skip_d   = 1'b1;
          status_d = ST_OK;
          state_d  = S_UPD;
          if (req_type_i == REQ_ALLOC) begin
            if (|grp_nf_q) begin
              word_d      = WIDX_W'(grp_first[GW-1:0]) << BIT_W;
              sum_re_o    = 1'b1;
              sum_raddr_o = grp_first[GW-1:0];
              state_d     = S_MAPRD;
            end else begin
              status_d = ST_FULL;
            end
          end else if (req_type_i == REQ_FREE || req_type_i == REQ_MARK) begin
            if ({1'b0, cluster_i[CLUSTER_W-1:BIT_W]} >= nwords_i) begin
              status_d = ST_RANGE;
            end else begin
              skip_d      = 1'b0;
              map_re_o    = 1'b1;
              map_raddr_o = cluster_i[AW+BIT_W-1:BIT_W];
              sum_re_o    = 1'b1;
              sum_raddr_o = cluster_i[GW+2*BIT_W-1:2*BIT_W];
            end
          end
        end
      end
      S_MAPRD: begin
        state_d = S_UPD;
        if ({1'b0, alloc_word} < nwords_i) begin
          word_d      = alloc_word;
          skip_d      = 1'b0;
          map_re_o    = 1'b1;
          map_raddr_o = alloc_word[AW-1:0];
        end else begin
          status_d = ST_FULL;
        end
      end
      S_UPD: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
          if (!skip_q) begin
            if (op_q == REQ_ALLOC) begin
              bit_oh        = WORD_BITS'(1) << map_first;
              map_new       = map_rdata_i | bit_oh;
              res_o.granted = {word_q, map_first};
            end else if (op_q == REQ_FREE) begin
              bit_oh  = WORD_BITS'(1) << bit_q;
              map_new = map_rdata_i & ~bit_oh;
            end else begin
              bit_oh  = WORD_BITS'(1) << bit_q;
              map_new = map_rdata_i | bit_oh;
            end
            sum_new = (sum_rdata_i & ~sub_oh) | ((&map_new) ? sub_oh : '0);
            map_we_o          = 1'b1;
            map_wdata_o       = map_new;
            sum_we_o          = 1'b1;
            sum_wdata_o       = sum_new;
            grp_nf_d[cur_grp] = ~(&sum_new);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/bitmap_cluster_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap cluster allocator
// Allocates, frees and marks clusters in a bitmap of 64-bit words.
// ----------------------------------------------------------------------------
// Requests enter on the input channel (req_type_i, cluster_i) under
// in_valid_i / in_stall_o and each gives one result (granted_cluster_o,
// status_o) under out_valid_o / out_stall_i. The words_in_use register is
// written through cfg_we_i / cfg_wdata_i; the user must write it only while
// no request is in flight (the block does not enforce this). One request is
// handled at a time. A free or mark request reads the bitmap and summary
// memories on acceptance and writes both back in the write-back step, which
// also registers its result. An allocate reads the summary memory, then the
// bitmap word it points to, then writes back both. A request that is out of
// range or uses the unused code goes straight to the write-back step, gives
// its result there and writes nothing. An allocate with no free cluster
// skips the bitmap read when every summary group is full; it writes nothing.
// After reset the block sweeps both memories to zero, one bitmap word per
// cycle, over MAP_WORDS words (capped at 1024); it stalls input meanwhile.
// A stalled result holds in the output register; the block then waits in
// its write-back step and keeps stalling input until the result is taken.
// ----------------------------------------------------------------------------
module bitmap_cluster_allocator
  import bca_pkg::*;
#(
  parameter int unsigned MAP_WORDS = MAP_WORDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [CLUSTER_W-1:0] cluster_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CLUSTER_W-1:0] granted_cluster_o,
  output logic [STATUS_W-1:0]  status_o
);

  localparam int unsigned DEPTH = (MAP_WORDS < WORD_REACH) ? MAP_WORDS : WORD_REACH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NG    = (DEPTH + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned GW    = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [CFG_W-1:0] DEPTH_CFG = CFG_W'(DEPTH);

  logic [CFG_W-1:0]     words_q;
  logic [CFG_W-1:0]     nwords;
  logic                 out_valid_q;
  res_t                 out_q;
  logic                 out_free;
  logic                 res_valid;
  res_t                 res;

  logic                 map_we, map_re;
  logic [AW-1:0]        map_waddr, map_raddr;
  logic [WORD_BITS-1:0] map_wdata, map_rdata;
  logic                 sum_we, sum_re;
  logic [GW-1:0]        sum_waddr, sum_raddr;
  logic [WORD_BITS-1:0] sum_wdata, sum_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= WORDS_RESET;
    end else if (cfg_we_i) begin
      words_q <= cfg_wdata_i;
    end
  end

  assign nwords   = (words_q < DEPTH_CFG) ? words_q : DEPTH_CFG;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign granted_cluster_o = out_q.granted;
  assign status_o          = out_q.status;

  bca_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .NG    (NG),
    .GW    (GW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .cluster_i   (cluster_i),
    .nwords_i    (nwords),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .map_we_o    (map_we),
    .map_waddr_o (map_waddr),
    .map_wdata_o (map_wdata),
    .map_re_o    (map_re),
    .map_raddr_o (map_raddr),
    .map_rdata_i (map_rdata),
    .sum_we_o    (sum_we),
    .sum_waddr_o (sum_waddr),
    .sum_wdata_o (sum_wdata),
    .sum_re_o    (sum_re),
    .sum_raddr_o (sum_raddr),
    .sum_rdata_i (sum_rdata)
  );

  bca_ram #(
    .WIDTH  (WORD_BITS),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bca_ram #(
    .WIDTH  (WORD_BITS),
    .DEPTH  (NG),
    .ADDR_W (GW)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

endmodule

// ----- sv/bca_checker.sv -----
// ----------------------------------------------------------------------------
// Bitmap cluster allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_cluster_allocator_macros.svh"

module bca_checker
  import bca_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_W-1:0]     cfg_wdata_i,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [REQ_W-1:0]     req_type_i,
  input logic [CLUSTER_W-1:0] cluster_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [CLUSTER_W-1:0] granted_cluster_o,
  input logic [STATUS_W-1:0]  status_o
);

  `BCA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(granted_cluster_o) && $stable(status_o), "Stalled result changed.")

  `BCA_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_o, status_o == ST_OK || status_o == ST_FULL || status_o == ST_RANGE, "Result carries an unused status code.")

  `BCA_ASSERT_NOW(a_grant_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK, granted_cluster_o == '0, "Failed request reports a granted cluster.")

  `BCA_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "Request accepted while another is in flight.")

endmodule

bind bitmap_cluster_allocator bca_checker u_bca_checker (.*);

// ----- sim/bitmap_cluster_allocator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap cluster allocator testbench
// Drives all four request codes under random idling on both sides.
// A bitmap predictor in the testbench works out each expected grant and
// status, and the monitor compares every result with the oldest expectation.
// ----------------------------------------------------------------------------
module bitmap_cluster_allocator_test;
  import bca_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE   = 2'd3;
  localparam int unsigned      CYCLE_LIMIT = 200000;
  localparam int unsigned      HOLD_CYCLES = 300;

  typedef struct packed {
    logic [REQ_W-1:0]     kind;
    logic [CLUSTER_W-1:0] cluster;
  } request_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [REQ_W-1:0]     req_type_i;
  logic [CLUSTER_W-1:0] cluster_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [CLUSTER_W-1:0] granted_cluster_o;
  logic [STATUS_W-1:0]  status_o;

  request_t             request_backlog[$];
  res_t                 awaited_grants[$];
  logic [WORD_BITS-1:0] model_map [MAP_WORDS_DEF];
  int unsigned          model_words = WORD_REACH;
  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;
  bit                   request_taken = 1'b0;
  bit                   result_taken = 1'b0;
  bit                   hold_request = 1'b0;
  int unsigned          send_wait = 0;
  int unsigned          send_calm = 0;
  int unsigned          recv_wait = 0;
  int unsigned          recv_calm = 0;
  int unsigned          hold_left = 0;

  bitmap_cluster_allocator i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .cluster_i         (cluster_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .granted_cluster_o (granted_cluster_o),
    .status_o          (status_o)
  );

  function automatic int unsigned clamp_words(input int unsigned n);
    int unsigned r;
    r = n;
    if (r > MAP_WORDS_DEF) r = MAP_WORDS_DEF;
    if (r > WORD_REACH) r = WORD_REACH;
    return r;
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic serve_request(input request_t r, output res_t res);
    int unsigned words;
    int unsigned w;
    int unsigned b;
    int unsigned i;
    words = clamp_words(model_words);
    w = r.cluster[CLUSTER_W-1:BIT_W];
    res.granted = '0;
    res.status = ST_OK;
    case (r.kind)
      REQ_ALLOC: begin
        res.status = ST_FULL;
        for (i = 0; i < words; i++) begin
          if (model_map[i] != '1) begin
            b = 0;
            while (model_map[i][b]) b++;
            model_map[i][b] = 1'b1;
            res.granted = CLUSTER_W'(i * WORD_BITS + b);
            res.status = ST_OK;
            break;
          end
        end
      end
      REQ_FREE, REQ_MARK: begin
        if (w >= words) begin
          res.status = ST_RANGE;
        end else begin
          model_map[w][r.cluster[BIT_W-1:0]] = (r.kind == REQ_MARK);
        end
      end
      default: begin
      end
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitmap_cluster_allocator_test: errors");
      $finish;
    end
  end

  // Monitor: checks results, then predicts each accepted request.
  always @(posedge clk_i) begin
    res_t     want;
    request_t seen;
    if (rst_ni) begin
      if (cfg_we_i) model_words = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        result_taken = 1'b1;
        if (awaited_grants.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, granted %0d status %0d", $time,
                   granted_cluster_o, status_o);
        end else begin
          want = awaited_grants.pop_front();
          if (granted_cluster_o !== want.granted) begin
            error_count++;
            $display("%0t: granted_cluster expected %0d, actual %0d", $time,
                     want.granted, granted_cluster_o);
          end
          if (status_o !== want.status) begin
            error_count++;
            $display("%0t: status expected %0d, actual %0d", $time,
                     want.status, status_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        request_taken = 1'b1;
        seen.kind = req_type_i;
        seen.cluster = cluster_i;
        serve_request(seen, want);
        awaited_grants.push_back(want);
      end
    end
  end

  // Driver: offers the next pending request after a random gap.
  always @(negedge clk_i) begin
    request_t nxt;
    if (rst_ni && !(in_valid_i && !request_taken)) begin
      request_taken = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
        in_valid_i <= 1'b0;
      end else if (request_backlog.size() > 0) begin
        nxt = request_backlog.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= nxt.kind;
        cluster_i <= nxt.cluster;
        send_wait = draw_wait(send_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stalls each result for a random count, or for a long hold.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (result_taken) begin
      result_taken = 1'b0;
      recv_wait = draw_wait(recv_calm);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (out_valid_o && recv_wait > 0) begin
      recv_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic queue_request(input logic [REQ_W-1:0] kind, input int unsigned clus);
    request_t r;
    r.kind = kind;
    r.cluster = clus[CLUSTER_W-1:0];
    request_backlog.push_back(r);
  endtask

  task automatic drain();
    while (request_backlog.size() > 0 || in_valid_i || awaited_grants.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_words(input int unsigned n);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CFG_W'(n);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned words, input int unsigned count,
                              input bit squeeze);
    int unsigned      span;
    int unsigned      pick;
    int unsigned      clus;
    logic [REQ_W-1:0] kind;
    drain();
    set_words(words);
    span = clamp_words(words) * WORD_BITS;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      clus = $urandom_range(0, 65535);
      if (pick < 45) begin
        kind = REQ_ALLOC;
      end else if (pick < 90) begin
        kind = (pick < 72) ? REQ_FREE : REQ_MARK;
        if (span > 0) clus = $urandom_range(0, span - 1);
      end else if (pick < 96) begin
        kind = pick[0] ? REQ_FREE : REQ_MARK;
      end else begin
        kind = REQ_SPARE;
      end
      queue_request(kind, clus);
    end
    if (squeeze) hold_request = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    req_type_i = REQ_ALLOC;
    cluster_i = '0;
    out_stall_i = 1'b0;
    foreach (model_map[k]) model_map[k] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_ALLOC, 65535);
    queue_request(REQ_MARK, 2);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 1);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 5);
    queue_request(REQ_MARK, 0);
    queue_request(REQ_MARK, 65535);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 65535);
    queue_request(REQ_FREE, 65535);
    queue_request(REQ_SPARE, 65535);
    queue_request(REQ_SPARE, 0);
    queue_request(REQ_MARK, 64);
    queue_request(REQ_FREE, 64);

    drain();
    set_words(2047);
    queue_request(REQ_MARK, 65535);
    queue_request(REQ_FREE, 65535);
    queue_request(REQ_ALLOC, 0);

    drain();
    set_words(0);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 0);
    queue_request(REQ_MARK, 0);
    queue_request(REQ_SPARE, 0);

    drain();
    set_words(1);
    queue_request(REQ_MARK, 64);
    queue_request(REQ_FREE, 3);
    repeat (66) queue_request(REQ_ALLOC, 0);
    queue_request(REQ_FREE, 63);
    queue_request(REQ_ALLOC, 0);
    queue_request(REQ_ALLOC, 0);

    random_phase(1, 50, 1'b0);
    random_phase(2, 60, 1'b1);
    random_phase($urandom_range(3, 8), 60, 1'b0);
    random_phase(1024, 50, 1'b0);
    random_phase(2047, 40, 1'b0);
    random_phase(0, 20, 1'b0);
    random_phase($urandom_range(1, 4), 60, 1'b0);

    drain();
    if (error_count == 0) begin
      $display("bitmap_cluster_allocator_test: clean");
    end else begin
      $display("bitmap_cluster_allocator_test: errors");
    end
    $finish;
  end

endmodule
